FILE: sv/tpps_pkg.sv
package tpps_pkg;

  localparam int TABLE_DEPTH = 128;
  localparam int ADDR_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam logic [7:0] DEPTH_CNT = 8'(TABLE_DEPTH);
  localparam int POT_W = 10;

  typedef struct packed {
    logic [7:0] a1;
    logic [6:0] a2;
    logic [6:0] a3;
    logic [5:0] a4;
  } pose_t;

  localparam int POSE_W = $bits(pose_t);

  typedef struct packed {
    logic load;
    logic exec;
  } cmd_t;

endpackage

FILE: sv/teach_playback_pose_sequencer_unit.sv
// Channel   Signals                                         Handshake
// -------   ----------------------------------------------  ------------------------
// item in   press_x press_o press_a pot_one..pot_four       start high, busy low
// result    drive_valid angle_one..angle_four mode_now      done high for one cycle
//           pose_count play_position
//
// For each item, the accept edge latches the inputs and reads the pose
// table at the playback index; the next cycle runs the menu step on that read data
// and the divide-by-1023 pot scaling, and registers the result.
// done is high in the cycle after busy; start may be taken in that same cycle.
// Synchronous reset clears the menu, the counters and the per-entry valid flags,
// so unwritten table entries read as zero; no clearing pass is needed.
// The receiver cannot stall: each result is shown for one cycle only.
module teach_playback_pose_sequencer_unit (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  output logic       busy,
  input  logic       press_x,
  input  logic       press_o,
  input  logic       press_a,
  input  logic [9:0] pot_one,
  input  logic [9:0] pot_two,
  input  logic [9:0] pot_three,
  input  logic [9:0] pot_four,
  output logic       done,
  output logic       drive_valid,
  output logic [7:0] angle_one,
  output logic [6:0] angle_two,
  output logic [6:0] angle_three,
  output logic [5:0] angle_four,
  output logic [2:0] mode_now,
  output logic [7:0] pose_count,
  output logic [7:0] play_position
);

  tpps_pkg::cmd_t cmd;

  tpps_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .cmd   (cmd),
    .busy  (busy)
  );

  tpps_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .press_x       (press_x),
    .press_o       (press_o),
    .press_a       (press_a),
    .pot_one       (pot_one),
    .pot_two       (pot_two),
    .pot_three     (pot_three),
    .pot_four      (pot_four),
    .done          (done),
    .drive_valid   (drive_valid),
    .angle_one     (angle_one),
    .angle_two     (angle_two),
    .angle_three   (angle_three),
    .angle_four    (angle_four),
    .mode_now      (mode_now),
    .pose_count    (pose_count),
    .play_position (play_position)
  );

endmodule

FILE: sv/tpps_ram.sv
module tpps_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: sv/tpps_scale.sv
module tpps_scale (
  input  logic [tpps_pkg::POT_W-1:0] pot_one,
  input  logic [tpps_pkg::POT_W-1:0] pot_two,
  input  logic [tpps_pkg::POT_W-1:0] pot_three,
  input  logic [tpps_pkg::POT_W-1:0] pot_four,
  output tpps_pkg::pose_t            pose
);

  // Truncating divide by 1023: estimate x*1025/2^20, then one correction step.
  function automatic logic [7:0] div1023(input logic [17:0] x);
    logic [18:0] sum;
    logic [8:0]  q0;
    logic [18:0] prod;
    logic [18:0] rem;
    sum  = {1'b0, x} + {11'd0, x[17:10]};
    q0   = sum[18:10];
    prod = {q0, 10'd0} - {10'd0, q0};
    rem  = {1'b0, x} - prod;
    if (rem >= 19'd1023) begin
      div1023 = q0[7:0] + 8'd1;
    end else begin
      div1023 = q0[7:0];
    end
  endfunction

  logic [17:0] x_one;
  logic [17:0] x_two;
  logic [17:0] x_three;
  logic [17:0] x_four;
  logic [7:0]  q_one;
  logic [7:0]  q_two;
  logic [7:0]  q_three;
  logic [7:0]  q_four;
  logic [7:0]  rev_four;

  assign x_one   = 18'(pot_one) * 18'd180;
  assign x_two   = 18'(pot_two) * 18'd90;
  assign x_three = 18'(pot_three) * 18'd90;
  assign x_four  = 18'(pot_four) * 18'd50;

  assign q_one   = div1023(x_one);
  assign q_two   = div1023(x_two);
  assign q_three = div1023(x_three);
  assign q_four  = div1023(x_four);

  // Joint four runs on a reversed scale.
  assign rev_four = 8'd50 - q_four;

  assign pose.a1 = q_one;
  assign pose.a2 = q_two[6:0];
  assign pose.a3 = q_three[6:0];
  assign pose.a4 = rev_four[5:0];

endmodule

FILE: sv/tpps_ctrl.sv
module tpps_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output tpps_pkg::cmd_t   cmd,
  output logic             busy
);

  typedef enum logic [1:0] {
    PH_IDLE = 2'b01,
    PH_EXEC = 2'b10
  } phase_t;

  phase_t phase;
  phase_t phase_next;

  always_comb begin
    phase_next = phase;
    unique case (phase)
      PH_IDLE: begin
        if (start) begin
          phase_next = PH_EXEC;
        end
      end
      PH_EXEC: phase_next = PH_IDLE;
      default: phase_next = PH_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
    end else begin
      phase <= phase_next;
    end
  end

  assign busy     = (phase == PH_EXEC);
  assign cmd.load = start && (phase == PH_IDLE);
  assign cmd.exec = (phase == PH_EXEC);

endmodule

FILE: sv/tpps_dp.sv
module tpps_dp (
  input  logic                       clk,
  input  logic                       rst,
  input  tpps_pkg::cmd_t             cmd,
  input  logic                       press_x,
  input  logic                       press_o,
  input  logic                       press_a,
  input  logic [tpps_pkg::POT_W-1:0] pot_one,
  input  logic [tpps_pkg::POT_W-1:0] pot_two,
  input  logic [tpps_pkg::POT_W-1:0] pot_three,
  input  logic [tpps_pkg::POT_W-1:0] pot_four,
  output logic                       done,
  output logic                       drive_valid,
  output logic [7:0]                 angle_one,
  output logic [6:0]                 angle_two,
  output logic [6:0]                 angle_three,
  output logic [5:0]                 angle_four,
  output logic [2:0]                 mode_now,
  output logic [7:0]                 pose_count,
  output logic [7:0]                 play_position
);

  typedef enum logic [6:0] {
    MENU_IDLE    = 7'b0000001,
    MENU_RUNARM  = 7'b0000010,
    MENU_RUNNING = 7'b0000100,
    MENU_ADDARM  = 7'b0001000,
    MENU_ADDING  = 7'b0010000,
    MENU_ASK     = 7'b0100000,
    MENU_ERASE   = 7'b1000000
  } menu_t;

  localparam logic [2:0] CODE_IDLE    = 3'd0;
  localparam logic [2:0] CODE_RUNARM  = 3'd1;
  localparam logic [2:0] CODE_RUNNING = 3'd2;
  localparam logic [2:0] CODE_ADDARM  = 3'd3;
  localparam logic [2:0] CODE_ADDING  = 3'd4;
  localparam logic [2:0] CODE_ASK     = 3'd5;
  localparam logic [2:0] CODE_ERASE   = 3'd6;

  function automatic logic [2:0] menu_code(input menu_t m);
    logic [2:0] c;
    unique case (m)
      MENU_IDLE:    c = CODE_IDLE;
      MENU_RUNARM:  c = CODE_RUNARM;
      MENU_RUNNING: c = CODE_RUNNING;
      MENU_ADDARM:  c = CODE_ADDARM;
      MENU_ADDING:  c = CODE_ADDING;
      MENU_ASK:     c = CODE_ASK;
      MENU_ERASE:   c = CODE_ERASE;
      default:      c = CODE_IDLE;
    endcase
    return c;
  endfunction

  // latched item
  logic                       px_q;
  logic                       po_q;
  logic                       pa_q;
  logic [tpps_pkg::POT_W-1:0] pot_one_q;
  logic [tpps_pkg::POT_W-1:0] pot_two_q;
  logic [tpps_pkg::POT_W-1:0] pot_three_q;
  logic [tpps_pkg::POT_W-1:0] pot_four_q;

  // menu state
  menu_t      menu;
  logic       refresh;
  logic [7:0] pose_total;
  logic [7:0] play_index;
  logic       going_fwd;
  logic       keep_run;
  logic       ping_pong;

  logic [tpps_pkg::TABLE_DEPTH-1:0] entry_valid;
  logic                             valid_q;

  tpps_pkg::pose_t                    live_pose;
  logic [tpps_pkg::POSE_W-1:0]        rd_bits;
  tpps_pkg::pose_t                    rd_pose;
  tpps_pkg::pose_t                    stored_pose;

  // step results
  menu_t                       menu_next;
  logic                        refresh_next;
  logic [7:0]                  total_next;
  logic [7:0]                  index_next;
  logic                        fwd_next;
  logic                        keep_next;
  logic                        pp_next;
  logic                        drv_next;
  tpps_pkg::pose_t             pose_next;
  logic                        wr_step;
  logic [tpps_pkg::ADDR_W-1:0] wr_addr;
  logic                        wr_en;

  tpps_scale u_scale (
    .pot_one   (pot_one_q),
    .pot_two   (pot_two_q),
    .pot_three (pot_three_q),
    .pot_four  (pot_four_q),
    .pose      (live_pose)
  );

  tpps_ram #(
    .WIDTH (tpps_pkg::POSE_W),
    .DEPTH (tpps_pkg::TABLE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (tpps_pkg::POSE_W'(live_pose)),
    .re    (cmd.load),
    .raddr (play_index[tpps_pkg::ADDR_W-1:0]),
    .rdata (rd_bits)
  );

  assign rd_pose = tpps_pkg::pose_t'(rd_bits);

  // Entries past the table or never written read as zero.
  assign stored_pose = (valid_q && (play_index < tpps_pkg::DEPTH_CNT)) ? rd_pose : '0;

  always_comb begin
    menu_next    = menu;
    refresh_next = refresh;
    total_next   = pose_total;
    index_next   = play_index;
    fwd_next     = going_fwd;
    keep_next    = keep_run;
    pp_next      = ping_pong;
    drv_next     = 1'b0;
    pose_next    = '0;
    wr_step      = 1'b0;
    wr_addr      = '0;

    // settle a pending menu refresh first
    if (refresh_next) begin
      unique case (menu_next)
        MENU_IDLE, MENU_ADDING, MENU_ASK, MENU_ERASE: refresh_next = 1'b0;
        MENU_RUNARM: begin
          keep_next = 1'b1;
          menu_next = MENU_RUNNING;
        end
        MENU_RUNNING: begin
          drv_next     = 1'b1;
          pose_next    = stored_pose;
          refresh_next = 1'b0;
        end
        MENU_ADDARM: begin
          menu_next    = MENU_ADDING;
          refresh_next = 1'b0;
        end
        default: refresh_next = refresh_next;
      endcase
    end

    if (px_q) begin
      if (menu_next == MENU_IDLE && total_next == '0) begin
        menu_next    = MENU_ADDARM;
        refresh_next = 1'b1;
      end
      if (menu_next == MENU_ERASE) begin
        total_next   = '0;
        menu_next    = MENU_IDLE;
        refresh_next = 1'b1;
      end
      if (menu_next == MENU_ADDING) begin
        // drop the capture when the table is full
        if (total_next < tpps_pkg::DEPTH_CNT) begin
          wr_step    = 1'b1;
          wr_addr    = total_next[tpps_pkg::ADDR_W-1:0];
          total_next = total_next + 8'd1;
        end
        refresh_next = 1'b1;
      end
      if (menu_next == MENU_RUNNING) begin
        if (pp_next) begin
          index_next = fwd_next ? index_next + 8'd1 : index_next - 8'd1;
          if (({1'b0, index_next} + 9'd1 >= {1'b0, total_next}) && keep_next) begin
            fwd_next = 1'b0;
          end
          if (index_next == '0) begin
            fwd_next = 1'b1;
          end
        end else begin
          if (({1'b0, index_next} + 9'd1 >= {1'b0, total_next}) && keep_next) begin
            index_next = '0;
          end else begin
            index_next = index_next + 8'd1;
          end
        end
        if (!keep_next && ((index_next >= total_next) ||
                           (index_next == 8'd1 && fwd_next))) begin
          menu_next  = MENU_IDLE;
          index_next = '0;
        end
        refresh_next = 1'b1;
      end
      if (menu_next == MENU_ASK) begin
        pp_next      = 1'b1;
        menu_next    = MENU_IDLE;
        refresh_next = 1'b1;
      end
    end

    if (po_q) begin
      if (total_next != '0 && menu_next == MENU_IDLE) begin
        index_next   = '0;
        menu_next    = MENU_RUNARM;
        refresh_next = 1'b1;
      end
      if (menu_next == MENU_ERASE) begin
        menu_next    = MENU_IDLE;
        refresh_next = 1'b1;
      end
      if (menu_next == MENU_ASK) begin
        pp_next      = 1'b0;
        menu_next    = MENU_IDLE;
        refresh_next = 1'b1;
      end
    end

    if (pa_q) begin
      if (menu_next == MENU_IDLE && total_next != '0) begin
        menu_next    = MENU_ERASE;
        refresh_next = 1'b1;
      end
      if (menu_next == MENU_ADDING) begin
        menu_next    = MENU_ASK;
        refresh_next = 1'b1;
      end
      if (menu_next == MENU_RUNNING) begin
        keep_next = 1'b0;
      end
    end

    // live pose follows the pots while recording
    if (menu_next == MENU_ADDING) begin
      drv_next  = 1'b1;
      pose_next = live_pose;
    end
  end

  assign wr_en = cmd.exec && wr_step;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      px_q        <= press_x;
      po_q        <= press_o;
      pa_q        <= press_a;
      pot_one_q   <= pot_one;
      pot_two_q   <= pot_two;
      pot_three_q <= pot_three;
      pot_four_q  <= pot_four;
      valid_q     <= entry_valid[play_index[tpps_pkg::ADDR_W-1:0]];
    end
    if (cmd.exec) begin
      drive_valid   <= drv_next;
      angle_one     <= pose_next.a1;
      angle_two     <= pose_next.a2;
      angle_three   <= pose_next.a3;
      angle_four    <= pose_next.a4;
      mode_now      <= menu_code(menu_next);
      pose_count    <= total_next;
      play_position <= index_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      menu        <= MENU_IDLE;
      refresh     <= 1'b0;
      pose_total  <= '0;
      play_index  <= '0;
      going_fwd   <= 1'b1;
      keep_run    <= 1'b0;
      ping_pong   <= 1'b0;
      entry_valid <= '0;
      done        <= 1'b0;
    end else begin
      done <= cmd.exec;
      if (cmd.exec) begin
        menu       <= menu_next;
        refresh    <= refresh_next;
        pose_total <= total_next;
        play_index <= index_next;
        going_fwd  <= fwd_next;
        keep_run   <= keep_next;
        ping_pong  <= pp_next;
      end
      if (wr_en) begin
        entry_valid[wr_addr] <= 1'b1;
      end
    end
  end

endmodule

FILE: sv/tpps_chk.sv
module tpps_chk (
  input logic       clk,
  input logic       rst,
  input logic       start,
  input logic       busy,
  input logic       done,
  input logic       drive_valid,
  input logic [7:0] angle_one,
  input logic [6:0] angle_two,
  input logic [6:0] angle_three,
  input logic [5:0] angle_four,
  input logic [2:0] mode_now,
  input logic [7:0] pose_count
);

  // an accepted item is worked on in the next cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("accepted item did not raise busy");

  // every working cycle ends in exactly one result transfer
  a_busy_done: assert property (@(posedge clk) disable iff (rst)
    busy |=> done && !busy)
    else $error("no result after working cycle");

  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe longer than one cycle");

  a_idle_angles: assert property (@(posedge clk) disable iff (rst)
    done && !drive_valid |-> angle_one == '0 && angle_two == '0 &&
                             angle_three == '0 && angle_four == '0)
    else $error("angles nonzero without drive");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    done |-> pose_count <= tpps_pkg::DEPTH_CNT && mode_now != 3'd7)
    else $error("pose count or menu code out of range");

endmodule

bind teach_playback_pose_sequencer_unit tpps_chk u_chk (
  .clk         (clk),
  .rst         (rst),
  .start       (start),
  .busy        (busy),
  .done        (done),
  .drive_valid (drive_valid),
  .angle_one   (angle_one),
  .angle_two   (angle_two),
  .angle_three (angle_three),
  .angle_four  (angle_four),
  .mode_now    (mode_now),
  .pose_count  (pose_count)
);

FILE: tb/tb_teach_playback_pose_sequencer_unit.sv
`timescale 1ns / 1ps

module tb_teach_playback_pose_sequencer_unit;

  typedef enum logic [2:0] {
    MENU_IDLE      = 3'd0,
    MENU_RUN_ARM   = 3'd1,
    MENU_RUNNING   = 3'd2,
    MENU_ADD_ARM   = 3'd3,
    MENU_ADDING    = 3'd4,
    MENU_ASK_MODE  = 3'd5,
    MENU_ERASE_ASK = 3'd6
  } menu_t;

  typedef struct packed {
    logic            drive;
    tpps_pkg::pose_t ang;
    logic [2:0]      mode;
    logic [7:0]      count;
    logic [7:0]      pos;
  } tick_result_t;

  typedef struct {
    logic         x;
    logic         o;
    logic         a;
    logic [9:0]   p1;
    logic [9:0]   p2;
    logic [9:0]   p3;
    logic [9:0]   p4;
    bit           typed;
    tick_result_t want;
  } stim_row_t;

  localparam int RANDOM_ITEMS = 850;

  logic       clk;
  logic       rst;
  logic       start;
  logic       busy;
  logic       press_x;
  logic       press_o;
  logic       press_a;
  logic [9:0] pot_one;
  logic [9:0] pot_two;
  logic [9:0] pot_three;
  logic [9:0] pot_four;
  logic       done;
  logic       drive_valid;
  logic [7:0] angle_one;
  logic [6:0] angle_two;
  logic [6:0] angle_three;
  logic [5:0] angle_four;
  logic [2:0] mode_now;
  logic [7:0] pose_count;
  logic [7:0] play_position;

  // typed expectation travels with the transfer it belongs to
  bit           cur_typed;
  tick_result_t cur_want;

  // sequencer mirror
  menu_t           menu;
  bit              refresh_due;
  tpps_pkg::pose_t pose_table [tpps_pkg::TABLE_DEPTH];
  int              stored_total;
  logic [7:0]      play_idx;
  bit              forward;
  bit              looping;
  bit              ping_pong;

  tick_result_t expected_ticks[$];
  stim_row_t    directed_rows[$];
  int           fail_count;
  int           results_seen;
  int           capture_goal;
  bit           filled_once;

  teach_playback_pose_sequencer_unit u_top (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .press_x      (press_x),
    .press_o      (press_o),
    .press_a      (press_a),
    .pot_one      (pot_one),
    .pot_two      (pot_two),
    .pot_three    (pot_three),
    .pot_four     (pot_four),
    .done         (done),
    .drive_valid  (drive_valid),
    .angle_one    (angle_one),
    .angle_two    (angle_two),
    .angle_three  (angle_three),
    .angle_four   (angle_four),
    .mode_now     (mode_now),
    .pose_count   (pose_count),
    .play_position(play_position)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #5000000;
    $display("tb: failure");
    $finish;
  end

  function automatic tpps_pkg::pose_t joint_angles(input logic [9:0] p1,
                                                   input logic [9:0] p2,
                                                   input logic [9:0] p3,
                                                   input logic [9:0] p4);
    tpps_pkg::pose_t p;
    p.a1 = 8'((int'(p1) * 180) / 1023);
    p.a2 = 7'((int'(p2) * 90) / 1023);
    p.a3 = 7'((int'(p3) * 90) / 1023);
    p.a4 = 6'(50 - (int'(p4) * 50) / 1023);
    return p;
  endfunction

  function automatic void clear_sequencer();
    menu = MENU_IDLE;
    refresh_due = 1'b0;
    for (int i = 0; i < tpps_pkg::TABLE_DEPTH; i++) pose_table[i] = '0;
    stored_total = 0;
    play_idx = 8'd0;
    forward = 1'b1;
    looping = 1'b0;
    ping_pong = 1'b0;
  endfunction

  // One control tick: settle a pending refresh, then X, O, A in that order.
  function automatic tick_result_t step_sequencer(input logic px, input logic po,
                                                  input logic pa,
                                                  input logic [9:0] p1, input logic [9:0] p2,
                                                  input logic [9:0] p3, input logic [9:0] p4);
    tick_result_t    r;
    tpps_pkg::pose_t cmd;
    logic            drv;
    cmd = '0;
    drv = 1'b0;
    if (refresh_due) begin
      unique case (menu)
        MENU_IDLE, MENU_ADDING, MENU_ASK_MODE, MENU_ERASE_ASK: refresh_due = 1'b0;
        MENU_RUN_ARM: begin
          looping = 1'b1;
          menu = MENU_RUNNING;
        end
        MENU_RUNNING: begin
          drv = 1'b1;
          if (int'(play_idx) < tpps_pkg::TABLE_DEPTH) cmd = pose_table[play_idx];
          refresh_due = 1'b0;
        end
        MENU_ADD_ARM: begin
          menu = MENU_ADDING;
          refresh_due = 1'b0;
        end
        default: ;
      endcase
    end

    if (px) begin
      if (menu == MENU_IDLE && stored_total == 0) begin
        menu = MENU_ADD_ARM;
        refresh_due = 1'b1;
      end
      if (menu == MENU_ERASE_ASK) begin
        stored_total = 0;
        menu = MENU_IDLE;
        refresh_due = 1'b1;
      end
      if (menu == MENU_ADDING) begin
        // drop the capture once the table is full
        if (stored_total < tpps_pkg::TABLE_DEPTH) begin
          pose_table[stored_total] = joint_angles(p1, p2, p3, p4);
          stored_total++;
        end
        refresh_due = 1'b1;
      end
      if (menu == MENU_RUNNING) begin
        if (ping_pong) begin
          play_idx = forward ? play_idx + 8'd1 : play_idx - 8'd1;
          if (int'(play_idx) + 1 >= stored_total && looping) forward = 1'b0;
          if (play_idx == 8'd0) forward = 1'b1;
        end else begin
          if (int'(play_idx) + 1 >= stored_total && looping) play_idx = 8'd0;
          else play_idx = play_idx + 8'd1;
        end
        if (!looping && (int'(play_idx) >= stored_total || (play_idx == 8'd1 && forward)))
        begin
          menu = MENU_IDLE;
          play_idx = 8'd0;
        end
        refresh_due = 1'b1;
      end
      if (menu == MENU_ASK_MODE) begin
        ping_pong = 1'b1;
        menu = MENU_IDLE;
        refresh_due = 1'b1;
      end
    end

    if (po) begin
      if (stored_total != 0 && menu == MENU_IDLE) begin
        play_idx = 8'd0;
        menu = MENU_RUN_ARM;
        refresh_due = 1'b1;
      end
      if (menu == MENU_ERASE_ASK) begin
        menu = MENU_IDLE;
        refresh_due = 1'b1;
      end
      if (menu == MENU_ASK_MODE) begin
        ping_pong = 1'b0;
        menu = MENU_IDLE;
        refresh_due = 1'b1;
      end
    end

    if (pa) begin
      if (menu == MENU_IDLE && stored_total != 0) begin
        menu = MENU_ERASE_ASK;
        refresh_due = 1'b1;
      end
      if (menu == MENU_ADDING) begin
        menu = MENU_ASK_MODE;
        refresh_due = 1'b1;
      end
      if (menu == MENU_RUNNING) looping = 1'b0;
    end

    if (menu == MENU_ADDING) begin
      drv = 1'b1;
      cmd = joint_angles(p1, p2, p3, p4);
    end

    r.drive = drv;
    r.ang   = drv ? cmd : '0;
    r.mode  = menu;
    r.count = 8'(stored_total);
    r.pos   = play_idx;
    return r;
  endfunction

  task automatic check_field(input string name, input logic [7:0] want,
                             input logic [7:0] got);
    if (got !== want) begin
      fail_count++;
      if (fail_count <= 10)
        $display("result %0d: %s expected %0d, got %0d", results_seen, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    tick_result_t want;
    if (!rst) begin
      if (done) begin
        if (expected_ticks.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) $display("result %0d: no transfer outstanding", results_seen);
        end else begin
          want = expected_ticks.pop_front();
          check_field("drive_valid", 8'(want.drive), 8'(drive_valid));
          check_field("angle_one", want.ang.a1, angle_one);
          check_field("angle_two", 8'(want.ang.a2), 8'(angle_two));
          check_field("angle_three", 8'(want.ang.a3), 8'(angle_three));
          check_field("angle_four", 8'(want.ang.a4), 8'(angle_four));
          check_field("mode_now", 8'(want.mode), 8'(mode_now));
          check_field("pose_count", want.count, pose_count);
          check_field("play_position", want.pos, play_position);
        end
        results_seen++;
      end
      if (start && !busy) begin
        want = step_sequencer(press_x, press_o, press_a, pot_one, pot_two, pot_three,
                              pot_four);
        expected_ticks.push_back(cur_typed ? cur_want : want);
      end
    end
  end

  task automatic add_row(input int x, input int o, input int a,
                         input int p1, input int p2, input int p3, input int p4,
                         input int typed, input int drv, input int a1, input int a2,
                         input int a3, input int a4, input menu_t m, input int cnt);
    stim_row_t row;
    row.x = 1'(x);
    row.o = 1'(o);
    row.a = 1'(a);
    row.p1 = 10'(p1);
    row.p2 = 10'(p2);
    row.p3 = 10'(p3);
    row.p4 = 10'(p4);
    row.typed = 1'(typed);
    row.want.drive = 1'(drv);
    row.want.ang.a1 = 8'(a1);
    row.want.ang.a2 = 7'(a2);
    row.want.ang.a3 = 7'(a3);
    row.want.ang.a4 = 6'(a4);
    row.want.mode = m;
    row.want.count = 8'(cnt);
    row.want.pos = 8'd0;
    directed_rows.push_back(row);
  endtask

  // Ends at a falling edge; unless no_gaps is set, may hold start low first.
  task automatic idle_gap(input bit no_gaps);
    @(negedge clk);
    if (!no_gaps) begin
      while ($urandom_range(0, 99) < 33) begin
        start <= 1'b0;
        @(negedge clk);
      end
    end
  endtask

  task automatic present_item(input stim_row_t row);
    press_x   <= row.x;
    press_o   <= row.o;
    press_a   <= row.a;
    pot_one   <= row.p1;
    pot_two   <= row.p2;
    pot_three <= row.p3;
    pot_four  <= row.p4;
    cur_typed <= row.typed;
    cur_want  <= row.want;
    start     <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  function automatic logic [9:0] pick_pot();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 10'd0;
    if (r == 1) return 10'd1023;
    return 10'($urandom_range(0, 1023));
  endfunction

  // Mostly presses that make sense for the current menu, with some noise.
  function automatic stim_row_t pick_item(input int n);
    stim_row_t row;
    int        r;
    logic [2:0] keys;
    row = '{default: '0};
    row.p1 = pick_pot();
    row.p2 = pick_pot();
    row.p3 = pick_pot();
    row.p4 = pick_pot();
    r = $urandom_range(0, 99);
    keys = 3'b000;
    if (menu != MENU_ADDING) capture_goal = 0;
    if ($urandom_range(0, 99) < 12) begin
      keys = 3'($urandom_range(0, 7));
    end else begin
      unique case (menu)
        MENU_IDLE: begin
          if (stored_total == 0) keys = (r < 85) ? 3'b100 : 3'b000;
          else if (r < 55) keys = 3'b010;
          else if (r < 80) keys = 3'b001;
        end
        MENU_ADDING: begin
          if (capture_goal == 0) begin
            if (!filled_once && n > 150) begin
              capture_goal = tpps_pkg::TABLE_DEPTH + 3;
              filled_once = 1'b1;
            end else if ($urandom_range(0, 9) == 0) begin
              capture_goal = $urandom_range(6, 20);
            end else begin
              capture_goal = $urandom_range(1, 5);
            end
          end
          if (r < 10) keys = 3'b000;
          else if (stored_total >= capture_goal) keys = 3'b001;
          else keys = 3'b100;
        end
        MENU_ASK_MODE: keys = (r < 50) ? 3'b100 : 3'b010;
        MENU_ERASE_ASK: begin
          if (r < 55) keys = 3'b100;
          else if (r < 90) keys = 3'b010;
        end
        MENU_RUNNING: begin
          if (r < 70) keys = 3'b100;
          else if (r < 85) keys = 3'b001;
        end
        default: ;
      endcase
    end
    row.x = keys[2];
    row.o = keys[1];
    row.a = keys[0];
    return row;
  endfunction

  initial begin
    rst = 1'b1;
    start = 1'b0;
    press_x = 1'b0;
    press_o = 1'b0;
    press_a = 1'b0;
    pot_one = '0;
    pot_two = '0;
    pot_three = '0;
    pot_four = '0;
    cur_typed = 1'b0;
    cur_want = '0;
    fail_count = 0;
    results_seen = 0;
    capture_goal = 0;
    filled_once = 1'b0;
    clear_sequencer();

    //     X  O  A  pot1  pot2  pot3  pot4  typ drv a1   a2  a3  a4  menu       count
    add_row(0, 0, 0, 0,    0,    0,    0,    1,  0,  0,   0,  0,  0, MENU_IDLE,      0);
    add_row(0, 1, 0, 1023, 1023, 1023, 1023, 1,  0,  0,   0,  0,  0, MENU_IDLE,      0);
    add_row(0, 0, 1, 1023, 0,    1023, 0,    1,  0,  0,   0,  0,  0, MENU_IDLE,      0);
    add_row(1, 0, 0, 0,    0,    0,    0,    1,  0,  0,   0,  0,  0, MENU_ADD_ARM,   0);
    add_row(0, 0, 0, 0,    0,    0,    0,    1,  1,  0,   0,  0,  50, MENU_ADDING,   0);
    add_row(0, 0, 0, 1023, 1023, 1023, 1023, 1,  1,  180, 90, 90, 0, MENU_ADDING,    0);
    add_row(1, 0, 0, 1023, 1023, 1023, 1023, 1,  1,  180, 90, 90, 0, MENU_ADDING,    1);
    add_row(1, 0, 0, 0,    0,    0,    0,    1,  1,  0,   0,  0,  50, MENU_ADDING,   2);
    add_row(1, 0, 0, 512,  300,  700,  1000, 0,  0,  0,   0,  0,  0, MENU_IDLE,      0);
    add_row(0, 0, 0, 341,  682,  85,   511,  0,  0,  0,   0,  0,  0, MENU_IDLE,      0);
    add_row(0, 0, 1, 100,  200,  300,  400,  1,  0,  0,   0,  0,  0, MENU_ASK_MODE,  3);
    add_row(0, 1, 0, 0,    0,    0,    0,    1,  0,  0,   0,  0,  0, MENU_IDLE,      3);
    add_row(0, 1, 0, 0,    0,    0,    0,    1,  0,  0,   0,  0,  0, MENU_RUN_ARM,   3);
    add_row(0, 0, 0, 0,    0,    0,    0,    1,  0,  0,   0,  0,  0, MENU_RUNNING,   3);
    add_row(0, 0, 0, 0,    0,    0,    0,    1,  1,  180, 90, 90, 0, MENU_RUNNING,   3);
    add_row(1, 0, 0, 0,    0,    0,    0,    0,  0,  0,   0,  0,  0, MENU_IDLE,      0);
    add_row(1, 0, 0, 0,    0,    0,    0,    0,  0,  0,   0,  0,  0, MENU_IDLE,      0);
    add_row(0, 0, 1, 0,    0,    0,    0,    0,  0,  0,   0,  0,  0, MENU_IDLE,      0);
    add_row(1, 0, 0, 0,    0,    0,    0,    0,  0,  0,   0,  0,  0, MENU_IDLE,      0);
    add_row(0, 0, 1, 0,    0,    0,    0,    1,  0,  0,   0,  0,  0, MENU_ERASE_ASK, 3);
    add_row(0, 1, 0, 0,    0,    0,    0,    1,  0,  0,   0,  0,  0, MENU_IDLE,      3);
    add_row(0, 0, 1, 0,    0,    0,    0,    1,  0,  0,   0,  0,  0, MENU_ERASE_ASK, 3);
    add_row(1, 0, 0, 0,    0,    0,    0,    1,  0,  0,   0,  0,  0, MENU_IDLE,      0);
    add_row(1, 1, 1, 1023, 0,    512,  1,    0,  0,  0,   0,  0,  0, MENU_IDLE,      0);

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) begin
      idle_gap(1'b0);
      present_item(directed_rows[i]);
    end

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      // long stretch with back-to-back transfers
      idle_gap(n >= 400 && n < 550);
      present_item(pick_item(n));
    end

    @(negedge clk);
    start <= 1'b0;
    while (expected_ticks.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (fail_count == 0 && expected_ticks.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

FILE: files.f
sv/tpps_pkg.sv
sv/tpps_ram.sv
sv/tpps_scale.sv
sv/tpps_ctrl.sv
sv/tpps_dp.sv
sv/teach_playback_pose_sequencer_unit.sv
sv/tpps_chk.sv
tb/tb_teach_playback_pose_sequencer_unit.sv
